// ===== src/itoa_pkg.sv =====
// Shared types, format codes and character constants for the integer to ASCII block.
// No dependencies; imported by itoa_bcd and integer_to_ascii_digits.
package itoa_pkg;

	localparam int VALUE_W = 64;
	localparam int BCD_DIGITS = 20;
	localparam int BCD_W = 4 * BCD_DIGITS;
	localparam int HEX_DIGITS = VALUE_W / 4;

	typedef enum logic [1:0] {
		FMT_DEC   = 2'd0,
		FMT_UHEX  = 2'd1,
		FMT_LHEX  = 2'd2,
		FMT_PTR   = 2'd3
	} fmt_t;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_X     = 8'h78;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;

	// Map one digit to its ASCII code; upper case only for the upper hex format
	function automatic logic [7:0] digit_char(input logic [3:0] d, input fmt_t fmt);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'd0, d};
		end else if (fmt == FMT_UHEX) begin
			c = CHAR_UPPER_A + {4'd0, d} - 8'd10;
		end else begin
			c = CHAR_LOWER_A + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

// ===== src/integer_to_ascii_digits.sv =====
// Top level: formats a 64-bit value as ASCII decimal, hex or pointer text.
// Depends on itoa_pkg and itoa_bcd.
//
// One item is handled at a time. A hex item is loaded on its input
// transfer and has 16 digit positions, each of which either drops a
// leading zero or sends a digit; the skip state then hands over to the
// emit state. The pointer form first sends the "0x" prefix. A decimal
// item is set by the bit-serial BCD converter, one magnitude bit per
// cycle, and its result is then taken. The minus sign is sent while
// the converter runs. The 20 BCD digit positions are then dropped or
// sent in the same way. The output register holds a finished character
// while the next input transfer is taken; a stall on the output side
// holds the prefix and digit emission.
module integer_to_ascii_digits
	import itoa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_char,
	output logic               last,
	output logic [31:0]        char_count
);

	localparam int REM_W = $clog2(BCD_DIGITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREFIX,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t             state_q;
	fmt_t               fmt_q;
	logic [1:0]         pre_q;
	logic [BCD_W-1:0]   dig_q;
	logic [REM_W-1:0]   rem_q;
	logic               out_valid_q;
	logic [7:0]         out_char_q;
	logic               last_q;
	logic [31:0]        count_q;

	logic               in_xfer;
	logic               can_load;
	logic               load_out;
	logic [7:0]         load_char;
	logic               load_last;
	fmt_t               in_fmt;
	logic               neg;
	logic [VALUE_W-1:0] mag;
	logic               bcd_done;
	logic [BCD_W-1:0]   bcd;
	logic [3:0]         top_digit;

	assign in_fmt    = fmt_t'(op);
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign can_load  = !out_valid_q || out_ready;
	assign neg       = (in_fmt == FMT_DEC) && value[VALUE_W-1];
	assign mag       = neg ? (~value + 1'b1) : value;
	assign top_digit = dig_q[BCD_W-1 -: 4];

	itoa_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer && (in_fmt == FMT_DEC)),
		.mag    (mag),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	// Pick the character for this cycle, if any
	always_comb begin
		load_out  = 1'b0;
		load_char = CHAR_ZERO;
		load_last = 1'b0;
		case (state_q)
			ST_PREFIX: begin
				load_out = can_load;
				if (fmt_q != FMT_PTR) begin
					load_char = CHAR_MINUS;
				end else if (pre_q == 2'd2) begin
					load_char = CHAR_ZERO;
				end else begin
					load_char = CHAR_X;
				end
			end
			ST_EMIT: begin
				load_out  = can_load;
				load_char = digit_char(top_digit, fmt_q);
				load_last = (rem_q == REM_W'(1));
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	// Sequence prefix, conversion, zero skip and digit emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fmt_q   <= FMT_DEC;
			pre_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						fmt_q <= in_fmt;
						if (in_fmt == FMT_PTR) begin
							pre_q   <= 2'd2;
							state_q <= ST_PREFIX;
						end else if (neg) begin
							pre_q   <= 2'd1;
							state_q <= ST_PREFIX;
						end else if (in_fmt == FMT_DEC) begin
							state_q <= ST_CONV;
						end else begin
							state_q <= ST_SKIP;
						end
						if (in_fmt != FMT_DEC) begin
							rem_q <= REM_W'(HEX_DIGITS);
						end
					end
				end
				ST_PREFIX: begin
					if (can_load) begin
						pre_q <= pre_q - 2'd1;
						if (pre_q == 2'd1) begin
							state_q <= (fmt_q == FMT_DEC) ? ST_CONV : ST_SKIP;
						end
					end
				end
				ST_CONV: begin
					if (bcd_done) begin
						rem_q   <= REM_W'(BCD_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (rem_q > REM_W'(1) && top_digit == 4'd0) begin
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (can_load) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Load and shift the digit register, most significant digit on top
	always_ff @(posedge clk) begin
		if (in_xfer && (in_fmt != FMT_DEC)) begin
			dig_q <= {value, {(BCD_W - VALUE_W){1'b0}}};
		end else if (state_q == ST_CONV && bcd_done) begin
			dig_q <= bcd;
		end else if ((state_q == ST_SKIP && rem_q > REM_W'(1) && top_digit == 4'd0) ||
			(state_q == ST_EMIT && can_load)) begin
			dig_q <= {dig_q[BCD_W-5:0], 4'd0};
		end
	end

	// Hold the output register until its transfer, count every character, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			if (count_q != 32'hFFFF_FFFF) begin
				count_q <= count_q + 32'd1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_char_q <= load_char;
			last_q     <= load_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign last       = last_q;
	assign char_count = count_q;

endmodule

// ===== src/itoa_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add three), one input bit per cycle.
// Depends on itoa_pkg for the value and BCD widths.
module itoa_bcd
	import itoa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] mag,
	output logic               done,
	output logic [BCD_W-1:0]   bcd
);

	localparam int CNT_W = $clog2(VALUE_W);

	logic [VALUE_W-1:0] sh_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [BCD_W-1:0]   adj;

	// Correct every digit that would pass nine after the next doubling
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Shift one magnitude bit into the BCD register per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(VALUE_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], sh_q[VALUE_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
